[src/bb3_pkg.sv]
package bb3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CH_W   = 8;
  localparam int LANES  = 3;
  localparam int PIX_W  = LANES * CH_W;
  localparam int FW_W   = 11;
  localparam int FH_W   = 16;
  localparam int ROW_W  = FH_W + 1;

  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int DIV_W       = 13;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 16;

  typedef struct packed {
    logic       load;
    logic [2:0] row_mask;
    logic [2:0] col_mask;
  } win_ctl_t;

  // ceil(2^16 / (2*n)) for the neighbour counts that can occur
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10923;
      4'd4:    m = 16'd8192;
      4'd6:    m = 16'd5462;
      4'd9:    m = 16'd3641;
      default: m = 16'd32768;
    endcase
    return m;
  endfunction

endpackage

[src/bb3_ram.sv]
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bb3_lane.sv]
module bb3_lane (
  input  logic                                 clk,
  input  bb3_pkg::win_ctl_t                    ctl,
  input  logic [2:0][2:0][bb3_pkg::CH_W-1:0]   px,
  output logic [bb3_pkg::CH_W-1:0]             mean
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]           sum;
  logic [SUM_W-1:0]           sum_next;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           cnt_next;
  logic [DIV_W-1:0]           dividend;
  logic [DIV_W+RECIP_W-1:0]   prod;

  always_comb begin
    sum_next = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (ctl.row_mask[r] && ctl.col_mask[c]) begin
          sum_next = sum_next + SUM_W'(px[r][c]);
        end
      end
    end
    cnt_next = CNT_W'($countones(ctl.row_mask)) * CNT_W'($countones(ctl.col_mask));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum <= sum_next;
      cnt <= cnt_next;
    end
  end

  // (2*sum + n) / (2*n) by reciprocal
  assign dividend = DIV_W'({sum, 1'b0}) + DIV_W'(cnt);
  assign prod     = (DIV_W+RECIP_W)'(dividend) * (DIV_W+RECIP_W)'(recip(cnt));
  assign mean     = prod[RECIP_SHIFT +: CH_W];

endmodule

[src/bb3_merge.sv]
module bb3_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        push,
  input  logic [bb3_pkg::LANES-1:0][bb3_pkg::CH_W-1:0] mean,
  input  logic                                        last,
  output logic                                        free,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [bb3_pkg::PIX_W-1:0]                   m_tdata,  // out_red, out_green, out_blue
  output logic                                        m_tlast   // end_of_frame
);
  import bb3_pkg::*;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= mean;
      m_tlast <= last;
    end
  end

endmodule

[src/box_blur_3x3_rgb.sv]
// 3x3 box blur over an RGB pixel stream in raster order. Set frame_width (byte address 0,
// 0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH) and frame_height (byte address 4,
// 0 acts as 1) while the block is idle; a write restarts the frame but keeps pending
// results. Each result is the per-channel mean of the in-frame 3x3 neighbours, with exact
// halves rounded up. Results lag the input by frame_width+1 positions, so after the last
// pixel send frame_width+1 flush items (tuser high) to drain the frame; tlast marks the last
// result. Pixels sent while draining and flushes sent before the frame is complete are
// dropped. A pixel item passes a registered line-store read, then the window update and lane
// sums, and when it yields a result, the reciprocal multiply into the output register, which
// waits while the output holds an untaken result. A flush may step the window twice, with a
// second line-store read between the steps. A waiting result holds up the next item only
// when that item yields a result. The line stores need no clearing pass after reset.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [bb3_pkg::PIX_W-1:0] s_tdata,   // in_red, in_green, in_blue
  input  logic                      s_tuser,   // cmd
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [bb3_pkg::PIX_W-1:0] m_tdata,   // out_red, out_green, out_blue
  output logic                      m_tlast,   // end_of_frame
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bb3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic CMD_PIXEL        = 1'b0;
  localparam logic CMD_FLUSH        = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADV   = 4'b0010,
    S_FETCH = 4'b0100,
    S_MEAN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [WW-1:0]    eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [ROW_W-1:0] h_ext;

  logic [AW-1:0]    ic;
  logic [AW:0]      ic_inc;
  logic             wrap;
  logic [ROW_W-1:0] ir;
  logic [ROW_W-1:0] crow;

  logic             has_pix;
  logic             retry;
  logic [PIX_W-1:0] pix;
  logic             eof_q;
  logic [2:0][PIX_W-1:0] win1;
  logic [2:0][PIX_W-1:0] win2;
  logic [2:0][PIX_W-1:0] newcol;

  logic             cfg_wr;
  logic             accept;
  logic             take;
  logic             case_a;
  logic             in_range;
  logic             produced;
  logic             eof_hit;
  logic             left_ok;
  logic             ram_re;
  logic             ram_we;
  logic [2*PIX_W-1:0] ram_rdata;
  logic             mfree;
  logic             push;
  win_ctl_t         ctl;

  logic [LANES-1:0][2:0][2:0][CH_W-1:0] lane_px;
  logic [LANES-1:0][CH_W-1:0]           lane_mean;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
    endcase
  end

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
    h_ext = {1'b0, eff_h};
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign take     = accept && ((s_tuser == CMD_FLUSH) ? (ir >= h_ext) : (ir < h_ext));

  assign case_a   = (ic == '0);
  assign in_range = case_a ? (ir >= ROW_W'(2) && ir <= h_ext + ROW_W'(1))
                           : (ir != '0 && ir <= h_ext);
  assign crow     = case_a ? ir - ROW_W'(2) : ir - ROW_W'(1);
  assign left_ok  = case_a ? (eff_w >= WW'(2)) : (ic >= AW'(2));
  assign eof_hit  = case_a && (ir == h_ext + ROW_W'(1));
  assign produced = (state == S_ADV) && in_range;

  assign ic_inc = {1'b0, ic} + (AW+1)'(1);
  assign wrap   = 32'(ic_inc) >= 32'(eff_w);

  assign newcol[0] = ram_rdata[2*PIX_W-1:PIX_W];
  assign newcol[1] = ram_rdata[PIX_W-1:0];
  assign newcol[2] = pix;

  assign ram_re = (state == S_IDLE && take) || (state == S_FETCH);
  assign ram_we = (state == S_ADV) && has_pix;

  bb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ic),
    .wdata ({ram_rdata[PIX_W-1:0], pix}),
    .re    (ram_re),
    .raddr (ic),
    .rdata (ram_rdata)
  );

  assign ctl.load     = produced;
  assign ctl.row_mask = {crow != h_ext - ROW_W'(1), 1'b1, crow != '0};
  assign ctl.col_mask = {!case_a, 1'b1, left_ok};

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      for (int r = 0; r < 3; r++) begin
        lane_px[c][r][0] = win1[r][c*CH_W +: CH_W];
        lane_px[c][r][1] = win2[r][c*CH_W +: CH_W];
        lane_px[c][r][2] = newcol[r][c*CH_W +: CH_W];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bb3_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .px   (lane_px[g]),
      .mean (lane_mean[g])
    );
  end

  assign push = (state == S_MEAN) && mfree;

  bb3_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .mean     (lane_mean),
    .last     (eof_q),
    .free     (mfree),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) state_next = S_ADV;
      end
      S_ADV: begin
        if (in_range) begin
          state_next = S_MEAN;
        end else if (!has_pix && retry) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: state_next = S_ADV;
      S_MEAN: begin
        if (mfree) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= FW_W'(1);
      frame_height <= FH_W'(1);
      ic           <= '0;
      ir           <= '0;
      has_pix      <= 1'b0;
      retry        <= 1'b0;
      win1         <= '0;
      win2         <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && take) begin
        has_pix <= (s_tuser == CMD_PIXEL);
        retry   <= (s_tuser == CMD_FLUSH);
      end
      if (state == S_ADV) begin
        win1  <= win2;
        win2  <= newcol;
        retry <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        endcase
        ic <= '0;
        ir <= '0;
      end else if (state == S_ADV) begin
        if (produced && eof_hit) begin
          ic <= '0;
          ir <= '0;
        end else if (wrap) begin
          ic <= '0;
          ir <= ir + ROW_W'(1);
        end else begin
          ic <= ic_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && take) begin
      pix <= (s_tuser == CMD_PIXEL) ? s_tdata : '0;
    end
    if (produced) begin
      eof_q <= eof_hit;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ic) < 32'(eff_w))
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    ir <= h_ext + ROW_W'(1))
    else $error("row counter beyond drain limit");

  a_read_then_adv: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> state == S_ADV)
    else $error("line read not followed by window update");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (produced && eof_hit && !cfg_wr) |=> (ic == '0 && ir == '0))
    else $error("frame end did not restart counters");
`endif

endmodule

[dv/box_blur_3x3_rgb_tb.sv]
`timescale 1ns / 100ps

module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  typedef enum logic [2:0] {
    FRAME_WIDTH_ADDR  = 3'd0,
    FRAME_HEIGHT_ADDR = 3'd4
  } reg_addr_e;

  typedef enum logic {
    PIXEL_ITEM = 1'b0,
    FLUSH_ITEM = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [PIX_W-1:0] rgb;
    logic             eof;
  } blurred_t;

  localparam int LINE_DEPTH = MAX_WIDTH_DEF;

  class rgb_blur_checker;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [PIX_W-1:0] upper_row [LINE_DEPTH];
    logic [PIX_W-1:0] middle_row [LINE_DEPTH];
    logic [PIX_W-1:0] win [3][3];
    int               in_row;
    int               in_col;
    blurred_t         blurred_due [$];
    int unsigned      mismatches;

    function new();
      int i;
      width_reg  = FW_W'(1);
      height_reg = FH_W'(1);
      for (i = 0; i < LINE_DEPTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
      in_row     = 0;
      in_col     = 0;
      mismatches = 0;
    endfunction

    function int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int eff_h();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function bit frame_done();
      return in_row >= eff_h();
    endfunction

    function void write_reg(reg_addr_e addr, logic [31:0] value);
      case (addr)
        FRAME_WIDTH_ADDR:  width_reg = value[FW_W-1:0];
        FRAME_HEIGHT_ADDR: height_reg = value[FH_W-1:0];
        default: ;
      endcase
      in_row = 0;
      in_col = 0;
    endfunction

    function blurred_t blur_at(int crow, int ccol, bit left, bit right, int h);
      int sum [LANES];
      int n, r, k, c, l;
      blurred_t res;
      n   = 0;
      res = '0;
      for (l = 0; l < LANES; l++) sum[l] = 0;
      for (k = 0; k < 3; k++) begin
        r = crow - 1 + k;
        if (r >= 0 && r < h) begin
          for (c = ccol - 1; c <= ccol + 1; c++) begin
            if ((c != ccol - 1 || left) && (c != ccol + 1 || right) && c >= 0 && c <= 2) begin
              for (l = 0; l < LANES; l++) sum[l] += win[k][c][CH_W*l +: CH_W];
              n++;
            end
          end
        end
      end
      if (n == 0) n = 1;
      for (l = 0; l < LANES; l++) begin
        res.rgb[CH_W*l +: CH_W] = CH_W'((2 * sum[l] + n) / (2 * n));
      end
      return res;
    endfunction

    function bit step_position(bit has_pix, logic [PIX_W-1:0] pix, output blurred_t res);
      int w, h, ic, ir, crow, ccol, k;
      bit made;
      w    = eff_w();
      h    = eff_h();
      ic   = in_col;
      ir   = in_row;
      made = 0;
      crow = 0;
      ccol = 0;
      res  = '0;
      if (ic >= w) ic = 0;
      if (ic == 0) begin
        crow = ir - 2;
        if (crow >= 0 && crow < h) begin
          res  = blur_at(crow, 2, w >= 2, 1'b0, h);
          ccol = w - 1;
          made = 1;
        end
      end
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = upper_row[ic];
      win[1][2] = middle_row[ic];
      win[2][2] = has_pix ? pix : '0;
      if (has_pix) begin
        upper_row[ic]  = middle_row[ic];
        middle_row[ic] = pix;
      end
      if (ic >= 1) begin
        crow = ir - 1;
        if (crow >= 0 && crow < h) begin
          res  = blur_at(crow, 1, ic >= 2, 1'b1, h);
          ccol = ic - 1;
          made = 1;
        end
      end
      ic++;
      if (ic >= w) begin
        ic = 0;
        in_row++;
      end
      in_col = ic;
      if (made && crow == h - 1 && ccol == w - 1) begin
        res.eof = 1'b1;
        in_row  = 0;
        in_col  = 0;
      end
      return made;
    endfunction

    // returns 0 when the item is dropped
    function bit take_item(item_kind_e kind, logic [PIX_W-1:0] pix);
      blurred_t r;
      int t;
      if (kind == PIXEL_ITEM) begin
        if (frame_done()) return 0;
        if (step_position(1'b1, pix, r)) blurred_due.push_back(r);
        return 1;
      end
      if (!frame_done()) return 0;
      for (t = 0; t < 2; t++) begin
        if (step_position(1'b0, '0, r)) begin
          blurred_due.push_back(r);
          break;
        end
      end
      return 1;
    endfunction

    function void check_blurred(logic [PIX_W-1:0] rgb, logic eof);
      string    lane_name [LANES] = '{"out_red", "out_green", "out_blue"};
      blurred_t want;
      int       l;
      if (blurred_due.size() == 0) begin
        $error("unexpected result: tdata %h tlast %b", rgb, eof);
        mismatches++;
        return;
      end
      want = blurred_due.pop_front();
      for (l = 0; l < LANES; l++) begin
        if (rgb[CH_W*l +: CH_W] !== want.rgb[CH_W*l +: CH_W]) begin
          $error("%s: expected %0d, actual %0d", lane_name[l],
                 want.rgb[CH_W*l +: CH_W], rgb[CH_W*l +: CH_W]);
          mismatches++;
        end
      end
      if (eof !== want.eof) begin
        $error("end_of_frame: expected %0d, actual %0d", want.eof, eof);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [PIX_W-1:0] s_tdata;   // in_red, in_green, in_blue
  logic             s_tuser;   // cmd
  logic             m_tvalid;
  logic             m_tready;
  logic [PIX_W-1:0] m_tdata;   // out_red, out_green, out_blue
  logic             m_tlast;   // end_of_frame
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  rgb_blur_checker sb;
  int unsigned     effective_items;
  int              src_idle_pct;
  int              sink_idle_pct;

  box_blur_3x3_rgb DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_blurred(m_tdata, m_tlast);
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    int l;
    for (l = 0; l < LANES; l++) begin
      case ($urandom_range(5))
        0:       p[CH_W*l +: CH_W] = '0;
        1:       p[CH_W*l +: CH_W] = '1;
        default: p[CH_W*l +: CH_W] = CH_W'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  task automatic push_item(input item_kind_e kind, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sb.take_item(kind, pix)) effective_items++;
  endtask

  task automatic apb_write(input reg_addr_e addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(addr, value);
    @(posedge clk);
  endtask

  // hold the input idle until every due result is out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.blurred_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic fill_frame(input int noise_pct);
    while (!sb.frame_done()) begin
      if ($urandom_range(99) < noise_pct) push_item(FLUSH_ITEM, rand_pixel());
      push_item(PIXEL_ITEM, rand_pixel());
    end
    while (sb.frame_done()) begin
      if ($urandom_range(99) < noise_pct) push_item(PIXEL_ITEM, rand_pixel());
      push_item(FLUSH_ITEM, rand_pixel());
    end
  endtask

  task automatic partial_frame(input int n_pix);
    repeat (n_pix) push_item(PIXEL_ITEM, rand_pixel());
  endtask

  task automatic random_frame();
    bit mid;
    settle();
    mid = (sb.in_row != 0 || sb.in_col != 0);
    if (mid || $urandom_range(3) != 0) begin
      apb_write(FRAME_WIDTH_ADDR,
                ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6));
    end
    if (mid || $urandom_range(3) != 0) begin
      apb_write(FRAME_HEIGHT_ADDR,
                ($urandom_range(24) == 0) ? 65535 : $urandom_range(0, 6));
    end
    if (sb.eff_h() > 64 || $urandom_range(9) == 0) begin
      partial_frame($urandom_range(0, 40));
    end else begin
      fill_frame(4);
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned quota;
    int          m;
    sb              = new();
    effective_items = 0;
    src_idle_pct    = 21;
    sink_idle_pct   = 61;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= PIXEL_ITEM;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= FRAME_WIDTH_ADDR;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single-pixel frame at reset settings
    push_item(PIXEL_ITEM, '1);
    push_item(FLUSH_ITEM, '0);
    settle();
    apb_write(FRAME_WIDTH_ADDR, 0);
    apb_write(FRAME_HEIGHT_ADDR, 0);
    push_item(PIXEL_ITEM, 24'h00FF00);
    push_item(FLUSH_ITEM, '1);
    settle();

    apb_write(FRAME_WIDTH_ADDR, 3);
    apb_write(FRAME_HEIGHT_ADDR, 2);
    push_item(FLUSH_ITEM, '0);
    push_item(PIXEL_ITEM, 24'hFF00FF);
    push_item(PIXEL_ITEM, 24'h00FF00);
    push_item(PIXEL_ITEM, 24'hFFFFFF);
    push_item(PIXEL_ITEM, 24'h000000);
    push_item(PIXEL_ITEM, 24'hFF00FF);
    push_item(PIXEL_ITEM, 24'h00FF00);
    push_item(PIXEL_ITEM, 24'hFFFFFF);
    while (sb.frame_done()) push_item(FLUSH_ITEM, '0);
    settle();

    // restart mid-frame, then run a full frame
    apb_write(FRAME_WIDTH_ADDR, 2);
    repeat (3) push_item(PIXEL_ITEM, '1);
    settle();
    apb_write(FRAME_HEIGHT_ADDR, 3);
    fill_frame(0);
    settle();

    // widest rows: cover the column counter wrap
    apb_write(FRAME_WIDTH_ADDR, $urandom_range(1) ? 1024 : 2047);
    apb_write(FRAME_HEIGHT_ADDR, 2);
    partial_frame(LINE_DEPTH + 12);

    base  = effective_items;
    quota = (base < 1850) ? (1850 - base) / 3 : 100;
    for (m = 0; m < 3; m++) begin
      case (m)
        0: begin
          src_idle_pct  = 21;
          sink_idle_pct = 61;
        end
        1: begin
          src_idle_pct  = 61;
          sink_idle_pct = 21;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      while (effective_items < base + (m + 1) * quota) random_frame();
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
